### hdl/stm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_pkg
// Shared types and constants for the slot table with end mark.
// ----------------------------------------------------------------------------
package stm_pkg;

   localparam int DATA_W      = 64;
   localparam int CNT_W       = 4;
   localparam int MAX_RESULTS = 8;
   localparam int SLOTS_DEF   = 8;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_TRAVERSE = 2'd2
   } stm_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_RM_READ,
      ST_RM_CHECK,
      ST_RM_TRIM,
      ST_TRV_READ,
      ST_TRV_CHECK,
      ST_EMIT
   } stm_state_type;

   typedef struct packed {
      logic              success;
      logic              entry_valid;
      logic [DATA_W-1:0] entry_value;
      logic [CNT_W-1:0]  entry_count;
      logic              last;
      logic              is_empty;
   } stm_rsp_type;

endpackage

### hdl/slot_table_with_end_mark.sv
`timescale 1ns / 1ps
// Scan: add, remove and traverse each walk the slots one index at a time.
// Throughput: one item at a time; the next item is taken once the last beat is
// in the output register, which holds it while the consumer stalls.
// Reset: synchronous, active high; clears the used bits, end mark and control state
// at once, so the table reads empty on the cycle after reset (no clearing pass).
// ----------------------------------------------------------------------------
// slot_table_with_end_mark
// Slot table with end mark: add, remove and traverse over SLOTS value slots.
// ----------------------------------------------------------------------------
module slot_table_with_end_mark #(
   parameter int SLOTS = stm_pkg::SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_operation,
   input  logic [stm_pkg::DATA_W-1:0] req_item_value,
   input  logic [stm_pkg::CNT_W-1:0]  req_max_entries,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_success,
   output logic                       rsp_entry_valid,
   output logic [stm_pkg::DATA_W-1:0] rsp_entry_value,
   output logic [stm_pkg::CNT_W-1:0]  rsp_entry_count,
   output logic                       rsp_last,
   output logic                       rsp_is_empty
);
   import stm_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic              out_free;
   logic              beat_valid;
   stm_rsp_type       beat;
   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [IW-1:0]     mem_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic [DATA_W-1:0] mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   stm_rsp_type       rsp_ff, rsp_in;

   stm_seq #(
      .SLOTS (SLOTS),
      .IW    (IW),
      .CW    (CW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_item_value  (req_item_value),
      .req_max_entries (req_max_entries),
      .out_free        (out_free),
      .beat_valid      (beat_valid),
      .beat            (beat),
      .mem_wr_en       (mem_wr_en),
      .mem_rd_en       (mem_rd_en),
      .mem_addr        (mem_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_data     (mem_rd_data)
   );

   stm_mem #(
      .SLOTS (SLOTS),
      .IW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // output register: a new beat may load in the cycle the held one is taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = beat_valid;
         if (beat_valid) begin
            rsp_in = beat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_ff.success;
   assign rsp_entry_valid = rsp_ff.entry_valid;
   assign rsp_entry_value = rsp_ff.entry_value;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_last        = rsp_ff.last;
   assign rsp_is_empty    = rsp_ff.is_empty;

endmodule

### hdl/stm_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_mem
// Slot value storage: one write and one registered read per cycle, both at the same address.
// ----------------------------------------------------------------------------
module stm_mem #(
   parameter int SLOTS = stm_pkg::SLOTS_DEF,
   parameter int IW    = 3
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic                      rd_en,
   input  logic [IW-1:0]             addr,
   input  logic [stm_pkg::DATA_W-1:0] wr_data,
   output logic [stm_pkg::DATA_W-1:0] rd_data
);
   import stm_pkg::*;

   logic [DATA_W-1:0] slot_ff [SLOTS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/stm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_seq
// Sequencer: walks the slots one index per step with a shared index counter
// and a 64-bit key compare used by remove; keeps the used bits and the end mark.
// ----------------------------------------------------------------------------
module stm_seq #(
   parameter int SLOTS = stm_pkg::SLOTS_DEF,
   parameter int IW    = 3,
   parameter int CW    = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_operation,
   input  logic [stm_pkg::DATA_W-1:0] req_item_value,
   input  logic [stm_pkg::CNT_W-1:0]  req_max_entries,
   input  logic                       out_free,
   output logic                       beat_valid,
   output stm_pkg::stm_rsp_type       beat,
   output logic                       mem_wr_en,
   output logic                       mem_rd_en,
   output logic [IW-1:0]              mem_addr,
   output logic [stm_pkg::DATA_W-1:0] mem_wr_data,
   input  logic [stm_pkg::DATA_W-1:0] mem_rd_data
);
   import stm_pkg::*;

   stm_state_type     state_ff, state_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  want_ff, want_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     end_mark_ff, end_mark_in;
   logic [SLOTS-1:0]  used_ff, used_in;
   logic [SLOTS-1:0]  rem_ff, rem_in;
   logic              ok_ff, ok_in;

   logic [IW-1:0]     ix;
   logic [CW-1:0]     em_dec;
   logic [IW-1:0]     em_ix;
   logic              key_zero;
   logic              idx_end;
   logic              at_lim;
   logic              hit;
   logic [SLOTS-1:0]  rem_next;
   logic [CNT_W-1:0]  cnt_inc;
   logic              trv_last;
   logic [CNT_W-1:0]  want_sat;
   logic              trim_more;

   assign ix        = idx_ff[IW-1:0];
   assign em_dec    = end_mark_ff - CW'(1);
   assign em_ix     = em_dec[IW-1:0];
   assign key_zero  = (req_item_value == '0);
   assign idx_end   = (idx_ff == CW'(SLOTS));
   assign at_lim    = (idx_ff == end_mark_ff);
   // free slots never match: the used bit gates the compare (the key is never zero here)
   assign hit       = used_ff[ix] && (mem_rd_data == key_ff);
   assign cnt_inc   = cnt_ff + CNT_W'(1);
   assign want_sat  = (req_max_entries > CNT_W'(MAX_RESULTS)) ?
                      CNT_W'(MAX_RESULTS) : req_max_entries;
   assign trim_more = (end_mark_ff != '0) && !used_ff[em_ix];

   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         rem_next[j] = rem_ff[j] && (IW'(j) != ix);
      end
   end

   // the entry is the last one if the count is met or no used slot remains
   assign trv_last  = (cnt_inc == want_ff) || (rem_next == '0);
   assign req_ready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_ADD:      state_in = key_zero ? ST_EMIT : ST_ADD_SCAN;
                  OP_REMOVE:   state_in = key_zero ? ST_EMIT : ST_RM_READ;
                  OP_TRAVERSE: state_in = (end_mark_ff == '0 || want_sat == '0) ?
                                          ST_EMIT : ST_TRV_READ;
                  default:     state_in = ST_EMIT;
               endcase
            end
         end
         ST_ADD_SCAN: begin
            if (idx_end || !used_ff[ix]) begin
               state_in = ST_EMIT;
            end
         end
         ST_RM_READ:   state_in = at_lim ? ST_EMIT : ST_RM_CHECK;
         ST_RM_CHECK:  state_in = hit ? ST_RM_TRIM : ST_RM_READ;
         ST_RM_TRIM: begin
            if (!trim_more) begin
               state_in = ST_EMIT;
            end
         end
         ST_TRV_READ: begin
            if (at_lim) begin
               state_in = ST_EMIT;
            end else if (used_ff[ix]) begin
               state_in = ST_TRV_CHECK;
            end
         end
         ST_TRV_CHECK: begin
            if (out_free) begin
               state_in = trv_last ? ST_IDLE : ST_TRV_READ;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      key_in      = key_ff;
      want_in     = want_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      end_mark_in = end_mark_ff;
      used_in     = used_ff;
      rem_in      = rem_ff;
      ok_in       = ok_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_addr    = ix;
      mem_wr_data = key_ff;
      beat_valid  = 1'b0;
      beat.success     = 1'b0;
      beat.entry_valid = 1'b0;
      beat.entry_value = '0;
      beat.entry_count = '0;
      beat.last        = 1'b1;
      beat.is_empty    = (end_mark_ff == '0);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in  = req_item_value;
               want_in = want_sat;
               idx_in  = '0;
               cnt_in  = '0;
               ok_in   = 1'b0;
               rem_in  = used_ff;
            end
         end
         ST_ADD_SCAN: begin
            if (idx_end) begin
               ok_in = 1'b0;
            end else if (!used_ff[ix]) begin
               mem_wr_en   = 1'b1;
               used_in[ix] = 1'b1;
               ok_in       = 1'b1;
               if (end_mark_ff <= idx_ff) begin
                  end_mark_in = idx_ff + CW'(1);
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_RM_READ: begin
            mem_rd_en = !at_lim;
         end
         ST_RM_CHECK: begin
            if (hit) begin
               used_in[ix] = 1'b0;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_RM_TRIM: begin
            if (trim_more) begin
               end_mark_in = em_dec;
            end else begin
               ok_in = 1'b1;
            end
         end
         ST_TRV_READ: begin
            if (!at_lim) begin
               if (used_ff[ix]) begin
                  mem_rd_en = 1'b1;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end
         ST_TRV_CHECK: begin
            if (out_free) begin
               beat_valid       = 1'b1;
               beat.entry_valid = 1'b1;
               beat.entry_value = mem_rd_data;
               beat.entry_count = cnt_inc;
               beat.last        = trv_last;
               cnt_in           = cnt_inc;
               rem_in           = rem_next;
               idx_in           = idx_ff + CW'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               beat_valid   = 1'b1;
               beat.success = ok_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         end_mark_ff <= '0;
         used_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         end_mark_ff <= end_mark_in;
         used_ff     <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      want_ff <= want_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      ok_ff   <= ok_in;
   end

`ifndef SYNTHESIS
   a_end_mark_range: assert property (@(posedge clock) disable iff (reset)
      end_mark_ff <= CW'(SLOTS))
      else $error("end mark beyond table");

   a_end_mark_tight: assert property (@(posedge clock) disable iff (reset)
      (end_mark_ff != '0 && state_ff != ST_RM_TRIM) |-> used_ff[em_ix])
      else $error("slot below end mark is free");

   // read data is held while a traverse beat waits on the output register
   a_read_fresh: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RM_CHECK || state_ff == ST_TRV_CHECK) && $changed(state_ff))
      |-> $past(mem_rd_en))
      else $error("compare on stale read data");

   a_trv_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRV_CHECK) |-> (cnt_ff < want_ff))
      else $error("traverse past requested count");
`endif

endmodule
